FILE: hdl/sihm_pkg.sv
// Shared types and constants for the string intern hash map.
// Used by sihm_ctrl, sihm_dp and string_intern_hash_map.
`default_nettype none
package sihm_pkg;

   localparam int unsigned SLOT_COUNT   = 512;
   localparam int unsigned MAX_NAMES    = 256;
   localparam int unsigned ARENA_BYTES  = 16384;
   localparam int unsigned MAX_NAME_LEN = 1024;
   localparam int unsigned ARENA_CAP    = ARENA_BYTES + MAX_NAME_LEN + 1;

   localparam int unsigned SLOT_W  = $clog2(SLOT_COUNT);
   localparam int unsigned IDX_W   = $clog2(MAX_NAMES);
   localparam int unsigned ID_W    = 9;
   localparam int unsigned OFF_W   = 14;
   localparam int unsigned LEN_W   = 11;
   localparam int unsigned STG_W   = $clog2(MAX_NAME_LEN);
   localparam int unsigned USED_W  = 15;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [2:0] {
      ST_FOUND      = 3'd0,
      ST_ADDED      = 3'd1,
      ST_BADNAME    = 3'd2,
      ST_IDS_OUT    = 3'd3,
      ST_ARENA_FULL = 3'd4,
      ST_PROBES_OUT = 3'd5,
      ST_UNMAP_MISS = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      RK_FOUND, RK_ADDED, RK_BAD, RK_IDS_OUT, RK_ARENA_FULL, RK_PROBES_OUT, RK_UNMAP
   } rsp_kind_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_UNMAP, S_CHECK, S_SLOT_RD, S_SLOT_CHK, S_ENTRY_CHK,
      S_NEXT, S_CMP_RD, S_CMP_CHK, S_COPY_RD, S_COPY_WR, S_COMMIT
   } state_type;

   typedef struct packed {
      logic         clr_step;
      logic         accept_byte;
      logic         unmap_rd;
      logic         probe_init;
      logic         probe_next;
      logic         slot_rd;
      logic         entry_rd;
      logic         cmp_init;
      logic         cmp_rd;
      logic         reserve;
      logic         copy_rd;
      logic         copy_wr;
      logic         commit;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic bad_name;
      logic held_zero;
      logic entry_ok;
      logic idx_done;
      logic cmp_eq;
      logic probes_done;
      logic ids_out;
      logic arena_full;
      logic rsp_busy;
   } sts_type;

endpackage
`default_nettype wire

FILE: hdl/sihm_ctrl.sv
// Sequencer for the string intern hash map: clear pass, staging, unmap, probe, compare, insert.
// Depends on sihm_pkg; drives sihm_dp through cmd_type, reads sts_type.
`default_nettype none
module sihm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_action,
   input  wire logic             req_last_byte,
   output logic                  req_stall,
   input  wire sihm_pkg::sts_type sts,
   output sihm_pkg::cmd_type     cmd,
   output sihm_pkg::state_type   state
);

   sihm_pkg::state_type state_ff, state_in;
   logic                accept;

   assign state = state_ff;
   assign req_stall = (state_ff != sihm_pkg::S_IDLE) ||
                      (sts.rsp_busy && (req_action || req_last_byte));
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sihm_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sihm_pkg::S_CLEAR: begin
            if (sts.clr_done) state_in = sihm_pkg::S_IDLE;
         end
         sihm_pkg::S_IDLE: begin
            if (accept && req_action) state_in = sihm_pkg::S_UNMAP;
            else if (accept && req_last_byte) state_in = sihm_pkg::S_CHECK;
         end
         sihm_pkg::S_UNMAP: state_in = sihm_pkg::S_IDLE;
         sihm_pkg::S_CHECK: begin
            state_in = sts.bad_name ? sihm_pkg::S_IDLE : sihm_pkg::S_SLOT_RD;
         end
         sihm_pkg::S_SLOT_RD: state_in = sihm_pkg::S_SLOT_CHK;
         sihm_pkg::S_SLOT_CHK: begin
            if (!sts.held_zero) state_in = sihm_pkg::S_ENTRY_CHK;
            else if (sts.ids_out || sts.arena_full) state_in = sihm_pkg::S_IDLE;
            else state_in = sihm_pkg::S_COPY_RD;
         end
         sihm_pkg::S_ENTRY_CHK: begin
            state_in = sts.entry_ok ? sihm_pkg::S_CMP_RD : sihm_pkg::S_NEXT;
         end
         sihm_pkg::S_NEXT: begin
            state_in = sts.probes_done ? sihm_pkg::S_IDLE : sihm_pkg::S_SLOT_RD;
         end
         sihm_pkg::S_CMP_RD: begin
            state_in = sts.idx_done ? sihm_pkg::S_IDLE : sihm_pkg::S_CMP_CHK;
         end
         sihm_pkg::S_CMP_CHK: begin
            state_in = sts.cmp_eq ? sihm_pkg::S_CMP_RD : sihm_pkg::S_NEXT;
         end
         sihm_pkg::S_COPY_RD: begin
            state_in = sts.idx_done ? sihm_pkg::S_COMMIT : sihm_pkg::S_COPY_WR;
         end
         sihm_pkg::S_COPY_WR: state_in = sihm_pkg::S_COPY_RD;
         sihm_pkg::S_COMMIT: state_in = sihm_pkg::S_IDLE;
         default: state_in = sihm_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_kind = sihm_pkg::RK_FOUND;
      unique case (state_ff)
         sihm_pkg::S_CLEAR: cmd.clr_step = 1'b1;
         sihm_pkg::S_IDLE: begin
            cmd.unmap_rd    = accept && req_action;
            cmd.accept_byte = accept && !req_action;
         end
         sihm_pkg::S_UNMAP: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = sihm_pkg::RK_UNMAP;
         end
         sihm_pkg::S_CHECK: begin
            cmd.probe_init = !sts.bad_name;
            cmd.rsp_load   = sts.bad_name;
            cmd.rsp_kind   = sihm_pkg::RK_BAD;
         end
         sihm_pkg::S_SLOT_RD: cmd.slot_rd = 1'b1;
         sihm_pkg::S_SLOT_CHK: begin
            cmd.entry_rd = !sts.held_zero;
            cmd.reserve  = sts.held_zero;
            cmd.cmp_init = 1'b1;
            cmd.rsp_load = sts.held_zero && (sts.ids_out || sts.arena_full);
            cmd.rsp_kind = sts.ids_out ? sihm_pkg::RK_IDS_OUT : sihm_pkg::RK_ARENA_FULL;
         end
         sihm_pkg::S_ENTRY_CHK: cmd.cmp_init = 1'b1;
         sihm_pkg::S_NEXT: begin
            cmd.probe_next = !sts.probes_done;
            cmd.rsp_load   = sts.probes_done;
            cmd.rsp_kind   = sihm_pkg::RK_PROBES_OUT;
         end
         sihm_pkg::S_CMP_RD: begin
            cmd.cmp_rd   = !sts.idx_done;
            cmd.rsp_load = sts.idx_done;
            cmd.rsp_kind = sihm_pkg::RK_FOUND;
         end
         sihm_pkg::S_CMP_CHK: ;
         sihm_pkg::S_COPY_RD: cmd.copy_rd = !sts.idx_done;
         sihm_pkg::S_COPY_WR: cmd.copy_wr = 1'b1;
         sihm_pkg::S_COMMIT: begin
            cmd.commit   = 1'b1;
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = sihm_pkg::RK_ADDED;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/sihm_dp.sv
// Datapath: staging buffer, FNV-1a hash, slot table, entry store, name arena, result register.
// Depends on sihm_pkg; steered by sihm_ctrl.
`default_nettype none
module sihm_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sihm_pkg::cmd_type           cmd,
   output sihm_pkg::sts_type                sts,
   input  wire logic [7:0]                  req_uri_byte,
   input  wire logic [sihm_pkg::ID_W-1:0]   req_urid,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [sihm_pkg::ID_W-1:0]        rsp_id_out,
   output logic [2:0]                       rsp_status,
   output logic [sihm_pkg::OFF_W-1:0]       rsp_arena_offset,
   output logic [sihm_pkg::LEN_W-1:0]       rsp_name_length,
   output logic                             rsp_first_overflow
);

   localparam int unsigned SW = sihm_pkg::SLOT_W;
   localparam int unsigned IW = sihm_pkg::IDX_W;

   // memories
   logic [7:0]                    stage_mem [sihm_pkg::MAX_NAME_LEN];
   logic [7:0]                    arena_mem [sihm_pkg::ARENA_BYTES];
   logic [sihm_pkg::ID_W-1:0]     slot_mem  [sihm_pkg::SLOT_COUNT];
   logic [sihm_pkg::OFF_W-1:0]    eoff_mem  [sihm_pkg::MAX_NAMES];
   logic [sihm_pkg::LEN_W-1:0]    elen_mem  [sihm_pkg::MAX_NAMES];

   logic [sihm_pkg::MAX_NAMES-1:0] valid_ff;
   logic [sihm_pkg::LEN_W-1:0]    stage_len_ff;
   logic [31:0]                   hash_ff;
   logic                          too_long_ff;
   logic [SW-1:0]                 slot_ff, probe_ff, clr_ff;
   logic [sihm_pkg::ID_W-1:0]     held_ff, urid_ff;
   logic [sihm_pkg::OFF_W-1:0]    eoff_q_ff, new_off_ff;
   logic [sihm_pkg::LEN_W-1:0]    elen_q_ff, idx_ff;
   logic [7:0]                    arena_q_ff, stage_q_ff;
   logic [sihm_pkg::ID_W-1:0]     resv_ff;
   logic [sihm_pkg::USED_W-1:0]   used_ff;
   logic [31:0]                   ovf_ff;
   logic [IW-1:0]                 new_idx_ff;
   logic                          rsp_valid_ff;
   logic [sihm_pkg::ID_W-1:0]     rsp_id_ff;
   logic [2:0]                    rsp_status_ff;
   logic [sihm_pkg::OFF_W-1:0]    rsp_off_ff;
   logic [sihm_pkg::LEN_W-1:0]    rsp_len_ff;
   logic                          rsp_first_ff;

   logic [31:0]                   hash_in;
   logic [15:0]                   size_w, used_sum;
   logic [IW-1:0]                 held_idx, urid_idx, entry_addr;
   logic                          unmap_hit, ovf_kind;

   assign hash_in  = (hash_ff ^ {24'd0, req_uri_byte}) * sihm_pkg::FNV_PRIME;
   assign size_w   = {5'd0, stage_len_ff} + 16'd1;
   assign used_sum = {1'b0, used_ff} + size_w;
   assign held_idx = IW'(held_ff - 9'd1);
   assign urid_idx = IW'(urid_ff - 9'd1);
   assign entry_addr = cmd.unmap_rd ? IW'(req_urid - 9'd1) : held_idx;
   assign unmap_hit = (urid_ff != '0) && ({7'd0, urid_ff} <= 16'(sihm_pkg::MAX_NAMES)) &&
                      (urid_ff <= resv_ff) && valid_ff[urid_idx];
   assign ovf_kind = (cmd.rsp_kind == sihm_pkg::RK_IDS_OUT) ||
                     (cmd.rsp_kind == sihm_pkg::RK_ARENA_FULL) ||
                     (cmd.rsp_kind == sihm_pkg::RK_PROBES_OUT);

   always_comb begin
      sts.clr_done    = (clr_ff == SW'(sihm_pkg::SLOT_COUNT - 1));
      sts.bad_name    = (stage_len_ff == '0) || too_long_ff;
      sts.held_zero   = (held_ff == '0);
      sts.entry_ok    = valid_ff[held_idx] && (elen_q_ff == stage_len_ff);
      sts.idx_done    = (idx_ff == stage_len_ff);
      sts.cmp_eq      = (arena_q_ff == stage_q_ff);
      sts.probes_done = (probe_ff == SW'(sihm_pkg::SLOT_COUNT - 1));
      sts.ids_out     = ({7'd0, resv_ff} >= 16'(sihm_pkg::MAX_NAMES));
      sts.arena_full  = ({1'b0, used_ff} > 16'(sihm_pkg::ARENA_BYTES) - size_w);
      sts.rsp_busy    = rsp_valid_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.accept_byte && req_uri_byte != 8'd0 &&
          stage_len_ff < sihm_pkg::LEN_W'(sihm_pkg::MAX_NAME_LEN)) begin
         stage_mem[stage_len_ff[sihm_pkg::STG_W-1:0]] <= req_uri_byte;
      end
      if (cmd.cmp_rd || cmd.copy_rd) begin
         stage_q_ff <= stage_mem[idx_ff[sihm_pkg::STG_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_wr) begin
         arena_mem[sihm_pkg::OFF_W'(new_off_ff + idx_ff)] <= stage_q_ff;
      end
      if (cmd.cmp_rd) begin
         arena_q_ff <= arena_mem[sihm_pkg::OFF_W'(eoff_q_ff + idx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         slot_mem[clr_ff] <= '0;
      end else if (cmd.commit) begin
         slot_mem[slot_ff] <= sihm_pkg::ID_W'({1'b0, new_idx_ff} + 9'd1);
      end
      if (cmd.slot_rd) begin
         held_ff <= slot_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         eoff_mem[new_idx_ff] <= new_off_ff;
         elen_mem[new_idx_ff] <= stage_len_ff;
      end
      if (cmd.entry_rd || cmd.unmap_rd) begin
         eoff_q_ff <= eoff_mem[entry_addr];
         elen_q_ff <= elen_mem[entry_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_len_ff <= '0;
         hash_ff      <= sihm_pkg::FNV_BASIS;
         too_long_ff  <= 1'b0;
         clr_ff       <= '0;
         valid_ff     <= '0;
         resv_ff      <= '0;
         used_ff      <= '0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + SW'(1);
         if (cmd.accept_byte && req_uri_byte != 8'd0) begin
            hash_ff <= hash_in;
            if (stage_len_ff < sihm_pkg::LEN_W'(sihm_pkg::MAX_NAME_LEN)) begin
               stage_len_ff <= stage_len_ff + 11'd1;
            end else begin
               too_long_ff <= 1'b1;
            end
         end
         if (cmd.reserve) begin
            if (!sts.ids_out) begin
               resv_ff <= resv_ff + 9'd1;
               used_ff <= (used_sum > 16'(sihm_pkg::ARENA_CAP)) ?
                          sihm_pkg::USED_W'(sihm_pkg::ARENA_CAP) : used_sum[14:0];
            end
         end
         if (cmd.commit) valid_ff[new_idx_ff] <= 1'b1;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (cmd.rsp_kind != sihm_pkg::RK_UNMAP) begin
               stage_len_ff <= '0;
               hash_ff      <= sihm_pkg::FNV_BASIS;
               too_long_ff  <= 1'b0;
            end
            if (ovf_kind && ovf_ff != 32'hFFFF_FFFF) ovf_ff <= ovf_ff + 32'd1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.unmap_rd) urid_ff <= req_urid;
      if (cmd.probe_init) begin
         slot_ff  <= hash_ff[SW-1:0];
         probe_ff <= '0;
      end
      if (cmd.probe_next) begin
         slot_ff  <= slot_ff + SW'(1);
         probe_ff <= probe_ff + SW'(1);
      end
      if (cmd.cmp_init) idx_ff <= '0;
      if (cmd.cmp_rd || cmd.copy_wr) idx_ff <= idx_ff + 11'd1;
      if (cmd.reserve) begin
         new_idx_ff <= resv_ff[IW-1:0];
         new_off_ff <= used_ff[sihm_pkg::OFF_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_id_ff    <= '0;
         rsp_off_ff   <= '0;
         rsp_len_ff   <= '0;
         rsp_first_ff <= ovf_kind && (ovf_ff == '0);
         case (cmd.rsp_kind)
            sihm_pkg::RK_FOUND: begin
               rsp_status_ff <= sihm_pkg::ST_FOUND;
               rsp_id_ff     <= held_ff;
            end
            sihm_pkg::RK_ADDED: begin
               rsp_status_ff <= sihm_pkg::ST_ADDED;
               rsp_id_ff     <= sihm_pkg::ID_W'({1'b0, new_idx_ff} + 9'd1);
            end
            sihm_pkg::RK_BAD:        rsp_status_ff <= sihm_pkg::ST_BADNAME;
            sihm_pkg::RK_IDS_OUT:    rsp_status_ff <= sihm_pkg::ST_IDS_OUT;
            sihm_pkg::RK_ARENA_FULL: rsp_status_ff <= sihm_pkg::ST_ARENA_FULL;
            sihm_pkg::RK_PROBES_OUT: rsp_status_ff <= sihm_pkg::ST_PROBES_OUT;
            default: begin
               if (unmap_hit) begin
                  rsp_status_ff <= sihm_pkg::ST_FOUND;
                  rsp_id_ff     <= urid_ff;
                  rsp_off_ff    <= eoff_q_ff;
                  rsp_len_ff    <= elen_q_ff;
               end else begin
                  rsp_status_ff <= sihm_pkg::ST_UNMAP_MISS;
               end
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_id_out         = rsp_id_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_arena_offset   = rsp_off_ff;
   assign rsp_name_length    = rsp_len_ff;
   assign rsp_first_overflow = rsp_first_ff;

endmodule
`default_nettype wire

FILE: hdl/string_intern_hash_map.sv
// A map byte without last_byte is staged; an unmap is answered from S_UNMAP.
// End of name: refused names answer from S_CHECK, ids or arena out from S_SLOT_CHK; found
// compares per byte, added copies per byte then commits; a passed probe goes via S_NEXT.
// Throughput: one name byte per cycle while staging, the last byte held while a result is
// undelivered; lookups run one at a time. Reset: synchronous; a pass then zeroes all 512 slots, req_stall high.
// Depends on sihm_pkg, sihm_ctrl, sihm_dp.
`default_nettype none
module string_intern_hash_map (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_uri_byte,
   input  wire logic        req_last_byte,
   input  wire logic [8:0]  req_urid,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [8:0]       rsp_id_out,
   output logic [2:0]       rsp_status,
   output logic [13:0]      rsp_arena_offset,
   output logic [10:0]      rsp_name_length,
   output logic             rsp_first_overflow
);

   sihm_pkg::cmd_type   cmd;
   sihm_pkg::sts_type   sts;
   sihm_pkg::state_type state;

   // sequencer: owns the handshake on the request side
   sihm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_action    (req_action),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd),
      .state         (state)
   );

   // storage, hash and result register
   sihm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_uri_byte       (req_uri_byte),
      .req_urid           (req_urid),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_id_out         (rsp_id_out),
      .rsp_status         (rsp_status),
      .rsp_arena_offset   (rsp_arena_offset),
      .rsp_name_length    (rsp_name_length),
      .rsp_first_overflow (rsp_first_overflow)
   );

   // no transfer is taken while the slot table is being cleared
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      state == sihm_pkg::S_CLEAR |-> req_stall)
      else $error("request taken during clear pass");

   // refused or missed results carry id zero
   a_refused_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sihm_pkg::ST_FOUND && rsp_status != sihm_pkg::ST_ADDED
      |-> rsp_id_out == 9'd0)
      else $error("nonzero id on refusal");

   // first-overflow flag only on capacity refusals
   a_first_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_overflow |->
      rsp_status == sihm_pkg::ST_IDS_OUT || rsp_status == sihm_pkg::ST_ARENA_FULL ||
      rsp_status == sihm_pkg::ST_PROBES_OUT)
      else $error("first overflow flag on wrong status");

   // a result load never lands on an undelivered result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid || !rsp_stall)
      else $error("result overwritten");

endmodule
`default_nettype wire
